FILE: rtl/core/delayed_task_slot_table_assert.svh
// Assertion macros shared by the delayed task slot table RTL.
// Needs nothing else; include it where concurrent checks are written.
`ifndef DELAYED_TASK_SLOT_TABLE_ASSERT_SVH
`define DELAYED_TASK_SLOT_TABLE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define DTST_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DTST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/dtst_pkg.sv
// Shared constants and types of the delayed task slot table.
// No dependencies; compile first.
package dtst_pkg;

	localparam int SLOTS_DEF      = 16;
	localparam int ID_BITS_DEF    = 8;
	localparam int DELAY_BITS_DEF = 16;

	localparam int INIT_SLOTS_RST = 8;
	localparam int MODE_W         = 2;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK   = 2'd0,
		MODE_ADD    = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_SLOTS = 1'b0,
		CFG_ALLOW_GROW    = 1'b1
	} cfg_idx_t;

	// Operation a token applies as it passes each cell.
	typedef enum logic [2:0] {
		WAVE_NOP    = 3'd0,
		WAVE_TICK   = 3'd1,
		WAVE_REMOVE = 3'd2,
		WAVE_PROBE  = 3'd3,
		WAVE_ALLOC  = 3'd4
	} wave_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_WAIT,
		ST_PROBE,
		ST_ALLOC_GO,
		ST_ALLOC_WAIT,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/core/dtst_intf.sv
// Valid/ready channel interfaces of the delayed task slot table.
// Depends on dtst_pkg for default widths.
interface dtst_req_if #(
	parameter int ID_BITS    = dtst_pkg::ID_BITS_DEF,
	parameter int DELAY_BITS = dtst_pkg::DELAY_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [dtst_pkg::MODE_W-1:0]   mode;
	logic [ID_BITS-1:0]            task_id;
	logic [DELAY_BITS-1:0]         delay;
	logic                          try_later;

	modport source (output valid, mode, task_id, delay, try_later, input ready);
	modport sink   (input valid, mode, task_id, delay, try_later, output ready);
endinterface

interface dtst_rsp_if #(
	parameter int SLOTS      = dtst_pkg::SLOTS_DEF,
	parameter int ID_BITS    = dtst_pkg::ID_BITS_DEF,
	parameter int DELAY_BITS = dtst_pkg::DELAY_BITS_DEF
);
	localparam int CW = $clog2(SLOTS + 1);

	logic                  valid;
	logic                  ready;
	logic                  ok;
	logic [DELAY_BITS-1:0] assigned_delay;
	logic                  ready_valid;
	logic [ID_BITS-1:0]    ready_task;
	logic [CW-1:0]         occupied_count;

	modport source (output valid, ok, assigned_delay, ready_valid, ready_task,
		occupied_count, input ready);
	modport sink   (input valid, ok, assigned_delay, ready_valid, ready_task,
		occupied_count, output ready);
endinterface

interface dtst_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [dtst_pkg::CFG_IDX_W-1:0]  index;
	logic [dtst_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/dtst_cell.sv
// One slot of the table: valid mark, task id and delay, plus a token register.
// Depends on dtst_pkg.
module dtst_cell #(
	parameter int SLOTS      = dtst_pkg::SLOTS_DEF,
	parameter int ID_BITS    = dtst_pkg::ID_BITS_DEF,
	parameter int DELAY_BITS = dtst_pkg::DELAY_BITS_DEF,
	parameter int IDX        = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clr,
	input  logic [$clog2(SLOTS+1)-1:0]     siu,
	input  logic [$bits(dtst_pkg::wave_kind_t)+DELAY_BITS+2*ID_BITS+$clog2(SLOTS+1)+2:0] tok_i,
	output logic [$bits(dtst_pkg::wave_kind_t)+DELAY_BITS+2*ID_BITS+$clog2(SLOTS+1)+2:0] tok_o
);
	localparam int CW = $clog2(SLOTS + 1);

	typedef struct packed {
		logic                 vld;
		dtst_pkg::wave_kind_t kind;
		logic [DELAY_BITS-1:0] dly;
		logic [ID_BITS-1:0]   tid;
		logic                 hit;
		logic [CW-1:0]        cnt;
		logic                 rdy;
		logic [ID_BITS-1:0]   rtask;
	} tok_t;

	tok_t                  tin;
	tok_t                  tok_d;
	tok_t                  tok_q;
	logic                  valid_q;
	logic                  valid_d;
	logic [ID_BITS-1:0]    task_q;
	logic [ID_BITS-1:0]    task_d;
	logic [DELAY_BITS-1:0] dly_q;
	logic [DELAY_BITS-1:0] dly_d;
	logic                  in_use;

	assign tin    = tok_i;
	assign tok_o  = tok_q;
	assign in_use = CW'(IDX) < siu;

	always_comb begin
		valid_d = valid_q;
		task_d  = task_q;
		dly_d   = dly_q;
		tok_d   = tin;
		if (tin.vld) begin
			case (tin.kind)
				dtst_pkg::WAVE_TICK: begin
					if (valid_q && dly_q != '0) dly_d = dly_q - 1'b1;
				end
				dtst_pkg::WAVE_REMOVE: begin
					if (valid_q && task_q == tin.tid) begin
						valid_d   = 1'b0;
						tok_d.hit = 1'b1;
					end
				end
				dtst_pkg::WAVE_PROBE: begin
					if (valid_q && dly_q == tin.dly) tok_d.hit = 1'b1;
				end
				dtst_pkg::WAVE_ALLOC: begin
					// claim the lowest free slot in use
					if (!tin.hit && !valid_q && in_use) begin
						valid_d   = 1'b1;
						task_d    = tin.tid;
						dly_d     = tin.dly;
						tok_d.hit = 1'b1;
					end
				end
				default: ;
			endcase
			// report on the state this cell leaves behind
			tok_d.cnt = tin.cnt + CW'(valid_d);
			if (!tin.rdy && valid_d && dly_d == '0) begin
				tok_d.rdy   = 1'b1;
				tok_d.rtask = task_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			valid_q <= clr ? 1'b0 : valid_d;
			tok_q   <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		task_q <= task_d;
		dly_q  <= dly_d;
	end

endmodule

FILE: rtl/core/dtst_chain.sv
// Row of slot cells; a token enters at slot 0 and leaves after the last slot.
// Depends on dtst_pkg and dtst_cell.
module dtst_chain #(
	parameter int SLOTS      = dtst_pkg::SLOTS_DEF,
	parameter int ID_BITS    = dtst_pkg::ID_BITS_DEF,
	parameter int DELAY_BITS = dtst_pkg::DELAY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clr,
	input  logic [$clog2(SLOTS+1)-1:0]     siu,
	input  logic [$bits(dtst_pkg::wave_kind_t)+DELAY_BITS+2*ID_BITS+$clog2(SLOTS+1)+2:0] tok_i,
	output logic [$bits(dtst_pkg::wave_kind_t)+DELAY_BITS+2*ID_BITS+$clog2(SLOTS+1)+2:0] tok_o
);
	localparam int TW = $bits(dtst_pkg::wave_kind_t) + DELAY_BITS + 2*ID_BITS
		+ $clog2(SLOTS + 1) + 3;

	logic [TW-1:0] link [SLOTS+1];

	assign link[0] = tok_i;
	assign tok_o   = link[SLOTS];

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		dtst_cell #(
			.SLOTS      (SLOTS),
			.ID_BITS    (ID_BITS),
			.DELAY_BITS (DELAY_BITS),
			.IDX        (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clr    (clr),
			.siu    (siu),
			.tok_i  (link[i]),
			.tok_o  (link[i+1])
		);
	end

endmodule

FILE: rtl/core/dtst_ctrl.sv
// Sequencer: launches tokens into the slot chain, decides add outcomes,
// holds registers and the result register. Depends on dtst_pkg and the interfaces.
`include "delayed_task_slot_table_assert.svh"
module dtst_ctrl #(
	parameter int SLOTS      = dtst_pkg::SLOTS_DEF,
	parameter int ID_BITS    = dtst_pkg::ID_BITS_DEF,
	parameter int DELAY_BITS = dtst_pkg::DELAY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dtst_req_if.sink                       req,
	dtst_rsp_if.source                     rsp,
	dtst_cfg_if.sink                       cfg,
	output logic                           clr,
	output logic [$clog2(SLOTS+1)-1:0]     siu,
	output logic [$bits(dtst_pkg::wave_kind_t)+DELAY_BITS+2*ID_BITS+$clog2(SLOTS+1)+2:0] launch,
	input  logic [$bits(dtst_pkg::wave_kind_t)+DELAY_BITS+2*ID_BITS+$clog2(SLOTS+1)+2:0] exit_tok
);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int RST_SIU = (dtst_pkg::INIT_SLOTS_RST > SLOTS) ? SLOTS
		: dtst_pkg::INIT_SLOTS_RST;
	localparam logic [DELAY_BITS-1:0] DMAX = {DELAY_BITS{1'b1}};

	typedef struct packed {
		logic                 vld;
		dtst_pkg::wave_kind_t kind;
		logic [DELAY_BITS-1:0] dly;
		logic [ID_BITS-1:0]   tid;
		logic                 hit;
		logic [CW-1:0]        cnt;
		logic                 rdy;
		logic [ID_BITS-1:0]   rtask;
	} tok_t;

	dtst_pkg::state_t      state_q;
	dtst_pkg::state_t      state_d;
	tok_t                  ex;
	tok_t                  ltok;

	dtst_pkg::mode_t       mode_q;
	logic [ID_BITS-1:0]    tid_q;
	logic [DELAY_BITS-1:0] dly_q;
	logic                  later_q;
	logic [CW-1:0]         siu_q;
	logic                  grow_q;
	logic [DELAY_BITS-1:0] cand_q;
	logic [CW-1:0]         nl_q;
	logic                  stop_q;
	logic [DELAY_BITS-1:0] alloc_q;

	logic                  res_ok_q;
	logic [DELAY_BITS-1:0] res_asg_q;
	logic                  res_rdy_q;
	logic [ID_BITS-1:0]    res_rtask_q;
	logic [CW-1:0]         res_cnt_q;

	logic                  rsp_valid_q;
	logic                  rsp_ok_q;
	logic [DELAY_BITS-1:0] rsp_asg_q;
	logic                  rsp_rdy_q;
	logic [ID_BITS-1:0]    rsp_rtask_q;
	logic [CW-1:0]         rsp_cnt_q;

	logic ex_done;
	logic ex_probe;
	logic ex_alloc;
	logic full;
	logic can_grow;
	logic last_probe;
	logic out_free;
	logic cfg_wr;

	assign ex       = exit_tok;
	assign launch   = ltok;
	assign siu      = siu_q;
	assign ex_done  = ex.vld && ex.kind != dtst_pkg::WAVE_PROBE;
	assign ex_probe = ex.vld && ex.kind == dtst_pkg::WAVE_PROBE;
	assign ex_alloc = ex.vld && ex.kind == dtst_pkg::WAVE_ALLOC;
	assign full     = ex.cnt == siu_q;
	assign can_grow = grow_q && siu_q < CW'(SLOTS);
	assign last_probe = !later_q || cand_q == DMAX || nl_q == CW'(SLOTS - 1);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign cfg_wr   = cfg.valid && cfg.ready;

	assign rsp.valid          = rsp_valid_q;
	assign rsp.ok             = rsp_ok_q;
	assign rsp.assigned_delay = rsp_asg_q;
	assign rsp.ready_valid    = rsp_rdy_q;
	assign rsp.ready_task     = rsp_rtask_q;
	assign rsp.occupied_count = rsp_cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dtst_pkg::ST_IDLE: begin
				if (req.valid) state_d = dtst_pkg::ST_LAUNCH;
			end
			dtst_pkg::ST_LAUNCH: state_d = dtst_pkg::ST_WAIT;
			dtst_pkg::ST_WAIT: begin
				if (ex_done) begin
					if (mode_q != dtst_pkg::MODE_ADD) state_d = dtst_pkg::ST_OUT;
					else if (full && !can_grow) state_d = dtst_pkg::ST_OUT;
					else state_d = dtst_pkg::ST_PROBE;
				end
			end
			dtst_pkg::ST_PROBE: begin
				if (ex_probe) begin
					if (!ex.hit) state_d = dtst_pkg::ST_ALLOC_GO;
					else if (!later_q || ex.dly == DMAX) state_d = dtst_pkg::ST_OUT;
				end
			end
			dtst_pkg::ST_ALLOC_GO: state_d = dtst_pkg::ST_ALLOC_WAIT;
			dtst_pkg::ST_ALLOC_WAIT: begin
				if (ex_alloc) state_d = dtst_pkg::ST_OUT;
			end
			dtst_pkg::ST_OUT: begin
				if (out_free) state_d = dtst_pkg::ST_IDLE;
			end
			default: state_d = dtst_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ltok      = '0;
		ltok.tid  = tid_q;
		req.ready = 1'b0;
		cfg.ready = 1'b1;
		clr       = cfg.valid && cfg.index == dtst_pkg::CFG_INITIAL_SLOTS;
		unique case (state_q)
			dtst_pkg::ST_IDLE: req.ready = 1'b1;
			dtst_pkg::ST_LAUNCH: begin
				ltok.vld = 1'b1;
				unique case (mode_q)
					dtst_pkg::MODE_TICK:   ltok.kind = dtst_pkg::WAVE_TICK;
					dtst_pkg::MODE_REMOVE: ltok.kind = dtst_pkg::WAVE_REMOVE;
					default:               ltok.kind = dtst_pkg::WAVE_NOP;
				endcase
			end
			dtst_pkg::ST_PROBE: begin
				ltok.vld  = !stop_q;
				ltok.kind = dtst_pkg::WAVE_PROBE;
				ltok.dly  = cand_q;
			end
			dtst_pkg::ST_ALLOC_GO: begin
				ltok.vld  = 1'b1;
				ltok.kind = dtst_pkg::WAVE_ALLOC;
				ltok.dly  = alloc_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dtst_pkg::ST_IDLE;
			siu_q       <= CW'(RST_SIU);
			grow_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (cfg.index)
					dtst_pkg::CFG_INITIAL_SLOTS: begin
						if (cfg.data == '0) siu_q <= CW'(1);
						else if (32'(cfg.data) > SLOTS) siu_q <= CW'(SLOTS);
						else siu_q <= CW'(cfg.data);
					end
					dtst_pkg::CFG_ALLOW_GROW: grow_q <= cfg.data[0];
					default: ;
				endcase
			end else if (state_q == dtst_pkg::ST_WAIT && ex_done
					&& mode_q == dtst_pkg::MODE_ADD && full && can_grow) begin
				// grow a full table by one slot
				siu_q <= siu_q + 1'b1;
			end
			if (state_q == dtst_pkg::ST_OUT && out_free) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dtst_pkg::ST_IDLE: begin
				if (req.valid) begin
					mode_q  <= dtst_pkg::mode_t'(req.mode);
					tid_q   <= req.task_id;
					dly_q   <= req.delay;
					later_q <= req.try_later;
				end
			end
			dtst_pkg::ST_WAIT: begin
				if (ex_done) begin
					res_rdy_q   <= ex.rdy;
					res_rtask_q <= ex.rdy ? ex.rtask : '0;
					res_cnt_q   <= ex.cnt;
					res_asg_q   <= '0;
					case (mode_q)
						dtst_pkg::MODE_REMOVE: res_ok_q <= ex.hit;
						dtst_pkg::MODE_ADD:    res_ok_q <= 1'b0;
						default:               res_ok_q <= 1'b1;
					endcase
					cand_q <= dly_q;
					nl_q   <= '0;
					stop_q <= 1'b0;
				end
			end
			dtst_pkg::ST_PROBE: begin
				if (!stop_q) begin
					cand_q <= cand_q + 1'b1;
					nl_q   <= nl_q + 1'b1;
					stop_q <= last_probe;
				end
				if (ex_probe && !ex.hit) alloc_q <= ex.dly;
			end
			dtst_pkg::ST_ALLOC_WAIT: begin
				if (ex_alloc) begin
					res_ok_q    <= ex.hit;
					res_asg_q   <= alloc_q;
					res_rdy_q   <= ex.rdy;
					res_rtask_q <= ex.rdy ? ex.rtask : '0;
					res_cnt_q   <= ex.cnt;
				end
			end
			dtst_pkg::ST_OUT: begin
				if (out_free) begin
					rsp_ok_q    <= res_ok_q;
					rsp_asg_q   <= res_asg_q;
					rsp_rdy_q   <= res_rdy_q;
					rsp_rtask_q <= res_rtask_q;
					rsp_cnt_q   <= res_cnt_q;
				end
			end
			default: ;
		endcase
	end

	`DTST_ASSERT_IMP(a_alloc_finds_slot, clk, arst_n, ex_alloc, ex.hit,
		"allocation token found no free slot")
	`DTST_ASSERT_ALWAYS(a_siu_range, clk, arst_n,
		siu_q != '0 && siu_q <= CW'(SLOTS), "slots in use out of range")
	`DTST_ASSERT_IMP(a_cnt_bound, clk, arst_n, ex_done, ex.cnt <= siu_q,
		"occupancy exceeds slots in use")
	`DTST_ASSERT_IMP(a_idle_drained, clk, arst_n, state_q == dtst_pkg::ST_IDLE, !ex.vld,
		"token left the chain while idle")

endmodule

FILE: rtl/core/delayed_task_slot_table.sv
// Delayed task slot table top level: sequencer plus a row of SLOTS slot cells.
// Tick, remove, query, and add into a full table that may not grow take one pass of the chain.
// Add probing k delays (k <= SLOTS): an occupancy pass, k probes, and an allocation pass
// when a probed delay is free; every pass is bound by the SLOTS-cell token chain.
// One transaction is worked at a time; the next is accepted while a result waits.
// Reset (arst_n low, asynchronous): all slots invalid, slots in use 8 (at most SLOTS).
module delayed_task_slot_table #(
	parameter int SLOTS      = dtst_pkg::SLOTS_DEF,
	parameter int ID_BITS    = dtst_pkg::ID_BITS_DEF,
	parameter int DELAY_BITS = dtst_pkg::DELAY_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dtst_req_if.sink   req,
	dtst_rsp_if.source rsp,
	dtst_cfg_if.sink   cfg
);
	// Width of one token: kind, delay, id, hit flag, count, ready flag, ready id, valid.
	localparam int CW = $clog2(SLOTS + 1);
	localparam int TW = $bits(dtst_pkg::wave_kind_t) + DELAY_BITS + 2*ID_BITS + CW + 3;

	// Token into slot 0 and token out of the last slot.
	logic [TW-1:0] launch;
	logic [TW-1:0] exit_tok;

	// Clear every valid mark when initial_slots is written.
	logic          clr;
	// Slots in use; cells at or above this index never take an allocation.
	logic [CW-1:0] siu;

	// The sequencer owns the handshakes, the registers and the result register.
	// It turns each transaction into tokens: tick and remove act in each cell as
	// the token passes; add first counts the occupancy, then streams candidate
	// delays one per cycle (the first to leave untaken wins, so the lowest free
	// delay at or above the request is found), then sends an allocation token.
	// Every token also gathers the ready task and the occupancy on its way.
	dtst_ctrl #(
		.SLOTS      (SLOTS),
		.ID_BITS    (ID_BITS),
		.DELAY_BITS (DELAY_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg      (cfg),
		.clr      (clr),
		.siu      (siu),
		.launch   (launch),
		.exit_tok (exit_tok)
	);

	// Each cell holds one slot and passes the token to its neighbor every cycle,
	// so a token visits the slots one after another, lowest slot first.
	dtst_chain #(
		.SLOTS      (SLOTS),
		.ID_BITS    (ID_BITS),
		.DELAY_BITS (DELAY_BITS)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr),
		.siu    (siu),
		.tok_i  (launch),
		.tok_o  (exit_tok)
	);

endmodule
